// ===== sv/booth_signed_multiplier_top_defines.svh =====
// Assertion macros for the Booth multiplier checker.
// No dependencies; included by bsm_checker.sv.
`ifndef BOOTH_SIGNED_MULTIPLIER_TOP_DEFINES_SVH
`define BOOTH_SIGNED_MULTIPLIER_TOP_DEFINES_SVH

// checked only outside reset
`define BSM_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("bsm assertion failed");

// checked at every edge, reset included
`define BSM_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("bsm assertion failed");

`endif

// ===== sv/bsm_pkg.sv =====
// Constants, types and the Booth step function of the multiplier.
// No dependencies; used by the interfaces and the top level.
package bsm_pkg;

  localparam int OPERAND_WIDTH   = 32;
  localparam int FIELD_WIDTH     = 32;
  localparam int STEPS_PER_STAGE = 4;
  localparam int NUM_STAGES      = (OPERAND_WIDTH + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
  localparam int IDX_W           = $clog2(OPERAND_WIDTH);

  typedef logic [OPERAND_WIDTH-1:0]      operand_t;
  typedef logic signed [FIELD_WIDTH-1:0] field_t;

  typedef struct packed {
    operand_t mcand;
    operand_t mplier;
    operand_t acc;
  } stage_t;

  // Applies Booth digits base .. base+STEPS_PER_STAGE-1 to the low-word accumulator.
  function automatic operand_t booth_group(input operand_t acc, input operand_t m,
                                           input operand_t q, input int unsigned base);
    operand_t    a;
    int unsigned i;
    logic        cur;
    logic        prv;
    a = acc;
    for (int unsigned k = 0; k < STEPS_PER_STAGE; k++) begin
      i = base + k;
      if (i < OPERAND_WIDTH) begin
        cur = q[i[IDX_W-1:0]];
        prv = (i == 0) ? 1'b0 : q[i[IDX_W-1:0] - 1'b1];
        if (cur && !prv) begin
          a = a - (m << i);
        end else if (!cur && prv) begin
          a = a + (m << i);
        end
      end
    end
    return a;
  endfunction

endpackage

// ===== sv/bsm_if.sv =====
// Valid/ready channels for operand words and product words.
// Depends on bsm_pkg.
interface bsm_op_if;
  import bsm_pkg::*;
  logic   valid;
  logic   ready;
  field_t multiplicand;
  field_t multiplier;
  modport source (output valid, output multiplicand, output multiplier, input ready);
  modport sink   (input valid, input multiplicand, input multiplier, output ready);
endinterface

interface bsm_res_if;
  import bsm_pkg::*;
  logic   valid;
  logic   ready;
  field_t product_low;
  modport source (output valid, output product_low, input ready);
  modport sink   (input valid, input product_low, output ready);
endinterface

// ===== sv/booth_signed_multiplier_top.sv =====
// Radix-2 Booth signed multiplier, low product word; uses bsm_pkg and bsm_if.
// Throughput: one word per cycle unless the output stalls; each stage applies
// four Booth digits (four chained 32-bit add/subtracts), and the last stage is
// the output register.
// Reset clears all stage valid bits asynchronously; payload is not reset.
module booth_signed_multiplier_top (
  input  logic      clk_i,
  input  logic      rst_ni,
  bsm_op_if.sink    op_i,
  bsm_res_if.source res_o
);
  import bsm_pkg::*;

  logic   valid_q [NUM_STAGES];
  stage_t data_q  [NUM_STAGES];
  logic   advance [NUM_STAGES];

  for (genvar s = 0; s < NUM_STAGES; s++) begin : g_stage
    logic   in_v;
    stage_t in_d;
    stage_t data_d;

    if (s == 0) begin : g_first
      assign in_v        = op_i.valid;
      assign in_d.mcand  = op_i.multiplicand[OPERAND_WIDTH-1:0];
      assign in_d.mplier = op_i.multiplier[OPERAND_WIDTH-1:0];
      assign in_d.acc    = '0;
    end else begin : g_mid
      assign in_v = valid_q[s-1];
      assign in_d = data_q[s-1];
    end

    if (s == NUM_STAGES - 1) begin : g_last
      assign advance[s] = !valid_q[s] || res_o.ready;
    end else begin : g_inner
      assign advance[s] = !valid_q[s] || advance[s+1];
    end

    always_comb begin
      data_d     = in_d;
      data_d.acc = booth_group(in_d.acc, in_d.mcand, in_d.mplier,
                               s * STEPS_PER_STAGE);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[s] <= 1'b0;
      end else if (advance[s]) begin
        valid_q[s] <= in_v;
      end
    end

    always_ff @(posedge clk_i) begin
      if (advance[s] && in_v) begin
        data_q[s] <= data_d;
      end
    end
  end

  assign op_i.ready        = advance[0];
  assign res_o.valid       = valid_q[NUM_STAGES-1];
  assign res_o.product_low = FIELD_WIDTH'(signed'(data_q[NUM_STAGES-1].acc));

endmodule

// ===== sv/bsm_checker.sv =====
// Port-level checks of the Booth multiplier, bound to its top level.
// Depends on bsm_pkg and booth_signed_multiplier_top_defines.svh.
`include "booth_signed_multiplier_top_defines.svh"

module bsm_checker (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  op_valid_i,
  input logic                  op_ready_i,
  input logic                  res_valid_i,
  input logic                  res_ready_i,
  input bsm_pkg::field_t       product_low_i
);
  import bsm_pkg::*;

  logic res_stall;

  assign res_stall = res_valid_i && !res_ready_i;

  // a stalled product word stays put
  `BSM_ASSERT(a_res_hold, clk_i, rst_ni, res_stall |=> res_valid_i && $stable(product_low_i))
  // the pipeline only refuses operands when the output is blocked
  `BSM_ASSERT(a_backpressure, clk_i, rst_ni, !op_ready_i |-> res_stall)
  // operand handshake lines and product valid are never unknown outside reset
  `BSM_ASSERT(a_known, clk_i, rst_ni, !$isunknown({op_valid_i, op_ready_i, res_valid_i}))
  // reset empties the pipeline
  `BSM_ASSERT_ALWAYS(a_reset_empty, clk_i, !rst_ni |=> !res_valid_i && op_ready_i)

endmodule

bind booth_signed_multiplier_top bsm_checker u_bsm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .op_valid_i    (op_i.valid),
  .op_ready_i    (op_i.ready),
  .res_valid_i   (res_o.valid),
  .res_ready_i   (res_o.ready),
  .product_low_i (res_o.product_low)
);
